// ===== hw/rtl/sws_pkg.sv =====
package sws_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_NEW  = 2'd0;
   localparam logic [1:0] FUNC_POLL = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // Command opcodes passed from the front to the back
   localparam logic [1:0] OP_NEW  = 2'd0;
   localparam logic [1:0] OP_POLL = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   // Outcome codes
   localparam logic [1:0] OUTCOME_NONE   = 2'd0;
   localparam logic [1:0] OUTCOME_ACKED  = 2'd1;
   localparam logic [1:0] OUTCOME_GAVEUP = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_NODE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_MS   = 2'd1;
   localparam logic [1:0] CSR_RESEND_LIMIT = 2'd2;

   localparam logic [7:0]  NODE_ADDRESS_RESET = 8'd0;
   localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd5000;
   localparam logic [7:0]  RESEND_LIMIT_RESET = 8'd3;

   localparam logic [7:0]  ACK_TYPE     = 8'h02;
   localparam logic [7:0]  SEQ_LAST     = 8'd254;
   localparam logic [7:0]  RESEND_MAX   = 8'hFF;
   localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] op;
      logic       ack_match;
      logic [7:0] frame_seq;
   } cmd_type;

endpackage

// ===== hw/rtl/sws_front.sv =====
module sws_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic             req_frame_valid,
   input  logic [7:0]       req_frame_receiver,
   input  logic [7:0]       req_frame_type,
   input  logic [7:0]       req_frame_sequence,
   input  logic [7:0]       node_address,
   output logic             push_valid,
   input  logic             push_ready,
   output sws_pkg::cmd_type push_data
);

   sws_pkg::cmd_type cmd;

   // Classify the request; the sequence compare waits for the back.
   always_comb begin
      cmd.ack_match = req_frame_valid && (req_frame_receiver == node_address)
                      && (req_frame_type == sws_pkg::ACK_TYPE);
      cmd.frame_seq = req_frame_sequence;
      unique case (req_func)
         sws_pkg::FUNC_NEW:  cmd.op = sws_pkg::OP_NEW;
         sws_pkg::FUNC_POLL: cmd.op = sws_pkg::OP_POLL;
         sws_pkg::FUNC_TICK: cmd.op = sws_pkg::OP_TICK;
         default:            cmd.op = sws_pkg::OP_NOP;
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign push_data  = cmd;

endmodule

// ===== hw/rtl/sws_queue.sv =====
module sws_queue #(
   parameter int DEPTH = sws_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sws_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sws_pkg::cmd_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   sws_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sws_back.sv =====
module sws_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   output logic [7:0]       node_address,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  sws_pkg::cmd_type pop_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_transmit,
   output logic [7:0]       rsp_sequence_res,
   output logic [1:0]       rsp_outcome,
   output logic [7:0]       rsp_resend_count
);

   logic [7:0]  node_address_ff;
   logic [15:0] timeout_ms_ff;
   logic [7:0]  resend_limit_ff;

   logic [7:0]  seq_ff, seq_in;
   logic        waiting_ff, waiting_in;
   logic [7:0]  resends_ff, resends_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        transmit_ff, transmit_in;
   logic [7:0]  sequence_ff;
   logic [1:0]  outcome_ff, outcome_in;
   logic [7:0]  count_ff, count_in;

   logic        fire;

   assign csr_ready    = 1'b1;
   assign node_address = node_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= sws_pkg::NODE_ADDRESS_RESET;
         timeout_ms_ff   <= sws_pkg::TIMEOUT_MS_RESET;
         resend_limit_ff <= sws_pkg::RESEND_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sws_pkg::CSR_NODE_ADDRESS: node_address_ff <= csr_data[7:0];
            sws_pkg::CSR_TIMEOUT_MS:   timeout_ms_ff   <= csr_data;
            sws_pkg::CSR_RESEND_LIMIT: resend_limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Take a command whenever the result register is empty or draining.
   assign pop_ready    = !rsp_valid_ff || rsp_ready;
   assign fire         = pop_valid && pop_ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      seq_in      = seq_ff;
      waiting_in  = waiting_ff;
      resends_in  = resends_ff;
      elapsed_in  = elapsed_ff;
      transmit_in = 1'b0;
      outcome_in  = sws_pkg::OUTCOME_NONE;
      count_in    = resends_ff;
      unique case (pop_data.op)
         sws_pkg::OP_NEW: begin
            seq_in      = (seq_ff == sws_pkg::SEQ_LAST) ? '0 : seq_ff + 8'd1;
            waiting_in  = 1'b1;
            elapsed_in  = '0;
            transmit_in = 1'b1;
         end
         sws_pkg::OP_TICK: begin
            if (elapsed_ff != sws_pkg::ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end
         sws_pkg::OP_POLL: begin
            if (waiting_ff) begin
               if (resends_ff > resend_limit_ff) begin
                  outcome_in = sws_pkg::OUTCOME_GAVEUP;
                  resends_in = '0;
                  waiting_in = 1'b0;
               end else if (pop_data.ack_match && (pop_data.frame_seq == seq_ff)) begin
                  outcome_in = sws_pkg::OUTCOME_ACKED;
                  resends_in = '0;
                  waiting_in = 1'b0;
               end else if (elapsed_ff > timeout_ms_ff) begin
                  if (resends_ff != sws_pkg::RESEND_MAX) begin
                     resends_in = resends_ff + 8'd1;
                  end
                  elapsed_in  = '0;
                  transmit_in = 1'b1;
                  count_in    = resends_in;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         waiting_ff   <= 1'b0;
         resends_ff   <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            seq_ff     <= seq_in;
            waiting_ff <= waiting_in;
            resends_ff <= resends_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         transmit_ff <= transmit_in;
         sequence_ff <= seq_in;
         outcome_ff  <= outcome_in;
         count_ff    <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_transmit     = transmit_ff;
   assign rsp_sequence_res = sequence_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_resend_count = count_ff;

endmodule

// ===== hw/rtl/stop_and_wait_sender_unit.sv =====
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  func, frame_valid, frame_receiver/type/sequence
// rsp       out  rsp_valid/rsp_ready  transmit, sequence_res, outcome, resend_count
// csr       in   csr_valid/csr_ready  csr_index (2 bit), csr_data (16 bit)
//
// One request per cycle sustained while rsp_ready stays high; an accepted request
// sits in the queue, moves into the response register when the back pops it and
// is presented from then on until rsp_ready takes it.
// The back updates state on each pop and pops one command per cycle unless stalled.
// Synchronous active-high reset clears the queue, the sequence state and the
// registers to their defaults. A stalled rsp_ready holds the response register
// and lets the queue fill; req_ready drops once the queue is full.
module stop_and_wait_sender_unit #(
   parameter int QUEUE_DEPTH = sws_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic       req_frame_valid,
   input  logic [7:0] req_frame_receiver,
   input  logic [7:0] req_frame_type,
   input  logic [7:0] req_frame_sequence,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_transmit,
   output logic [7:0] rsp_sequence_res,
   output logic [1:0] rsp_outcome,
   output logic [7:0] rsp_resend_count,
   // configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);

   logic             push_valid, push_ready;
   logic             pop_valid, pop_ready;
   sws_pkg::cmd_type push_data, pop_data;
   logic [7:0]       node_address;

   // Front: decode the function and pre-match the acknowledgement header.
   sws_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_frame_valid    (req_frame_valid),
      .req_frame_receiver (req_frame_receiver),
      .req_frame_type     (req_frame_type),
      .req_frame_sequence (req_frame_sequence),
      .node_address       (node_address),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_data          (push_data)
   );

   // Queue: decouple request acceptance from response back-pressure.
   sws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: advance sequence, timer and resend state, register the response.
   sws_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .node_address     (node_address),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_transmit     (rsp_transmit),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_outcome      (rsp_outcome),
      .rsp_resend_count (rsp_resend_count)
   );

endmodule

// ===== test/tb_stop_and_wait_sender_unit.sv =====
module tb_stop_and_wait_sender_unit;

   // Codes the package leaves unnamed: the spare function and the spare register slot
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam logic [1:0] CSR_SPARE  = 2'd3;

   localparam int unsigned BURST_MAX     = 18;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned SETTLE_CYCLES = 10;

   typedef struct packed {
      logic [1:0] func;
      logic       frame_valid;
      logic [7:0] frame_receiver;
      logic [7:0] frame_type;
      logic [7:0] frame_seq;
   } request_type;

   typedef struct packed {
      logic       transmit;
      logic [7:0] seq_num;
      logic [1:0] outcome;
      logic [7:0] resend_count;
   } status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = sws_pkg::FUNC_TICK;
   logic        req_frame_valid = 1'b0;
   logic [7:0]  req_frame_receiver = '0;
   logic [7:0]  req_frame_type = '0;
   logic [7:0]  req_frame_sequence = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_transmit;
   logic [7:0]  rsp_sequence_res;
   logic [1:0]  rsp_outcome;
   logic [7:0]  rsp_resend_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = sws_pkg::CSR_NODE_ADDRESS;
   logic [15:0] csr_data = '0;

   // Mirror of the sender: sequence state plus the three registers
   logic [7:0]  model_seq;
   logic        model_waiting;
   logic [7:0]  model_resends;
   logic [15:0] model_elapsed;
   logic [7:0]  cfg_node;
   logic [15:0] cfg_timeout;
   logic [7:0]  cfg_limit;

   status_type  status_q[$];
   int unsigned mismatches = 0;
   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;

   stop_and_wait_sender_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_frame_valid    (req_frame_valid),
      .req_frame_receiver (req_frame_receiver),
      .req_frame_type     (req_frame_type),
      .req_frame_sequence (req_frame_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_transmit       (rsp_transmit),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_outcome        (rsp_outcome),
      .rsp_resend_count   (rsp_resend_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Fail the run if it hangs; the slowest legal run is far shorter than this
   initial begin
      #80_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Advance the mirrored sender by one request and return the status it reports.
   // On acknowledge or give-up the reported count is the one before clearing.
   function automatic status_type advance_sender(request_type r);
      status_type s;
      s.transmit     = 1'b0;
      s.outcome      = sws_pkg::OUTCOME_NONE;
      s.resend_count = model_resends;
      case (r.func)
         sws_pkg::FUNC_NEW: begin
            model_seq     = (model_seq == sws_pkg::SEQ_LAST) ? 8'd0 : model_seq + 8'd1;
            model_waiting = 1'b1;
            model_elapsed = '0;
            s.transmit    = 1'b1;
         end
         sws_pkg::FUNC_TICK: begin
            if (model_elapsed != sws_pkg::ELAPSED_MAX)
               model_elapsed = model_elapsed + 16'd1;
         end
         sws_pkg::FUNC_POLL: begin
            if (model_waiting) begin
               if (model_resends > cfg_limit) begin
                  s.outcome     = sws_pkg::OUTCOME_GAVEUP;
                  model_resends = '0;
                  model_waiting = 1'b0;
               end else if (r.frame_valid && r.frame_receiver == cfg_node &&
                            r.frame_seq == model_seq &&
                            r.frame_type == sws_pkg::ACK_TYPE) begin
                  s.outcome     = sws_pkg::OUTCOME_ACKED;
                  model_resends = '0;
                  model_waiting = 1'b0;
               end else if (model_elapsed > cfg_timeout) begin
                  if (model_resends != sws_pkg::RESEND_MAX)
                     model_resends = model_resends + 8'd1;
                  model_elapsed  = '0;
                  s.transmit     = 1'b1;
                  s.resend_count = model_resends;
               end
            end
         end
         default: ;
      endcase
      s.seq_num = model_seq;
      return s;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [15:0] data);
      case (idx)
         sws_pkg::CSR_NODE_ADDRESS: cfg_node    = data[7:0];
         sws_pkg::CSR_TIMEOUT_MS:   cfg_timeout = data;
         sws_pkg::CSR_RESEND_LIMIT: cfg_limit   = data[7:0];
         default: ;
      endcase
   endfunction

   task automatic note_mismatch(string what, int unsigned want, int unsigned got);
      if (mismatches < REPORT_LIMIT)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      mismatches++;
   endtask

   // Compare every accepted response against the oldest prediction
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_q.size() == 0) begin
            note_mismatch("response with nothing pending", 0, 1);
         end else begin
            want = status_q.pop_front();
            if (rsp_transmit != want.transmit)
               note_mismatch("transmit", want.transmit, rsp_transmit);
            if (rsp_sequence_res != want.seq_num)
               note_mismatch("sequence_res", want.seq_num, rsp_sequence_res);
            if (rsp_outcome != want.outcome)
               note_mismatch("outcome", want.outcome, rsp_outcome);
            if (rsp_resend_count != want.resend_count)
               note_mismatch("resend_count", want.resend_count, rsp_resend_count);
         end
      end
   end

   // Stall the response side in random bursts; hold ready high when idling is off
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, BURST_MAX) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Present one request and hold it until accepted. Valid stays high on return so
   // back-to-back requests never drop and raise it in the same step.
   task automatic send_request(logic [1:0] func, logic fv, logic [7:0] receiver,
                               logic [7:0] ftype, logic [7:0] fseq);
      request_type r;
      r = '{func: func, frame_valid: fv, frame_receiver: receiver,
            frame_type: ftype, frame_seq: fseq};
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, BURST_MAX)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= r.func;
      req_frame_valid    <= r.frame_valid;
      req_frame_receiver <= r.frame_receiver;
      req_frame_type     <= r.frame_type;
      req_frame_sequence <= r.frame_seq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      status_q.push_back(advance_sender(r));
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   // Write all three registers back to back; upper data bits of the byte
   // registers carry random junk that must be dropped
   task automatic program_config(logic [7:0] node, logic [15:0] timeout, logic [7:0] limit);
      drain_responses();
      csr_write(sws_pkg::CSR_NODE_ADDRESS, {8'($urandom), node});
      csr_write(sws_pkg::CSR_TIMEOUT_MS, timeout);
      csr_write(sws_pkg::CSR_RESEND_LIMIT, {8'($urandom), limit});
      csr_valid <= 1'b0;
   endtask

   // Default registers: polls while not waiting, the spare code, a bare tick
   task automatic test_idle_behavior();
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'h00, sws_pkg::ACK_TYPE, 8'h00);
      send_request(FUNC_SPARE, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      send_request(sws_pkg::FUNC_TICK, 1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_request(sws_pkg::FUNC_POLL, 1'b0, 8'h00, sws_pkg::ACK_TYPE, 8'h00);
   endtask

   // Resend on timeout, new packet while waiting keeps the count, give-up,
   // an acknowledge with frame_valid low, and a proper acknowledge
   task automatic test_resend_and_giveup();
      drain_responses();
      csr_write(CSR_SPARE, 16'($urandom));
      program_config(8'hA5, 16'd2, 8'd1);
      send_request(sws_pkg::FUNC_NEW, 1'b0, 8'h00, 8'h00, 8'h00);
      send_request(sws_pkg::FUNC_POLL, 1'b0, 8'hA5, sws_pkg::ACK_TYPE, model_seq);
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'hA5, 8'h03, model_seq);
      repeat (3) send_request(sws_pkg::FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00);
      send_request(sws_pkg::FUNC_POLL, 1'b0, 8'h00, 8'h00, 8'h00);
      send_request(sws_pkg::FUNC_NEW, 1'b1, 8'hA5, sws_pkg::ACK_TYPE, 8'h00);
      repeat (3) send_request(sws_pkg::FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00);
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'hA4, sws_pkg::ACK_TYPE, model_seq);
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'hA5, sws_pkg::ACK_TYPE, model_seq);
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'hA5, sws_pkg::ACK_TYPE, model_seq);
      send_request(sws_pkg::FUNC_NEW, 1'b0, 8'h00, 8'h00, 8'h00);
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'hA5, sws_pkg::ACK_TYPE, model_seq);
      send_request(FUNC_SPARE, 1'b0, 8'h00, 8'h00, 8'h00);
   endtask

   // Walk the sequence number past 254 so it wraps to 0, then acknowledge
   task automatic test_sequence_wrap();
      program_config(8'hFF, 16'd1, 8'd0);
      repeat (256) send_request(sws_pkg::FUNC_NEW, 1'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
      send_request(sws_pkg::FUNC_POLL, 1'b1, 8'hFF, sws_pkg::ACK_TYPE, model_seq);
   endtask

   // Largest limit: resends climb to 255, then the next poll gives up
   task automatic test_resend_ceiling();
      program_config(8'h00, 16'd1, 8'd254);
      send_request(sws_pkg::FUNC_NEW, 1'b0, 8'h00, 8'h00, 8'h00);
      repeat (256) begin
         repeat (2) send_request(sws_pkg::FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00);
         send_request(sws_pkg::FUNC_POLL, 1'b0, 8'($urandom), 8'($urandom),
                      8'($urandom));
      end
   endtask

   // Mostly well-formed traffic: packets, ticks, spare codes and polls whose frames
   // are an exact acknowledge, an acknowledge with one field broken, or noise
   task automatic test_random_traffic(int unsigned count);
      int unsigned pick;
      int unsigned field;
      logic [1:0]  func;
      logic        fv;
      logic [7:0]  receiver, ftype, fseq;
      for (int unsigned i = 0; i < count; i++) begin
         // Hold off once mid-phase until the response side has caught up
         if (i == count / 2) drain_responses();
         pick     = $urandom_range(0, 99);
         fv       = 1'($urandom);
         receiver = 8'($urandom);
         ftype    = 8'($urandom);
         fseq     = 8'($urandom);
         if (pick < 10) func = sws_pkg::FUNC_NEW;
         else if (pick < 50) func = sws_pkg::FUNC_TICK;
         else if (pick < 95) func = sws_pkg::FUNC_POLL;
         else func = FUNC_SPARE;
         if (func == sws_pkg::FUNC_POLL && $urandom_range(0, 9) < 7) begin
            fv       = 1'b1;
            receiver = cfg_node;
            ftype    = sws_pkg::ACK_TYPE;
            fseq     = model_seq;
            if ($urandom_range(0, 6) >= 3) begin
               field = $urandom_range(0, 3);
               case (field)
                  0: fv = 1'b0;
                  1: receiver = receiver ^ 8'($urandom_range(1, 255));
                  2: ftype = ftype ^ 8'($urandom_range(1, 255));
                  default: fseq = fseq ^ 8'($urandom_range(1, 255));
               endcase
            end
         end
         send_request(func, fv, receiver, ftype, fseq);
      end
   endtask

   initial begin
      logic [15:0] timeout;
      logic [7:0]  limit;
      model_seq     = '0;
      model_waiting = 1'b0;
      model_resends = '0;
      model_elapsed = '0;
      cfg_node      = sws_pkg::NODE_ADDRESS_RESET;
      cfg_timeout   = sws_pkg::TIMEOUT_MS_RESET;
      cfg_limit     = sws_pkg::RESEND_LIMIT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_behavior();
      test_resend_and_giveup();
      test_sequence_wrap();
      test_resend_ceiling();

      for (int phase = 0; phase < 4; phase++) begin
         timeout = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65534))
                                               : 16'($urandom_range(1, 6));
         limit   = ($urandom_range(0, 4) == 0) ? 8'd254 : 8'($urandom_range(0, 3));
         if (phase == 0) timeout = 16'd1;
         if (phase == 3) idle_on = 1'b0;
         program_config(8'($urandom), timeout, limit);
         test_random_traffic(130);
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && status_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
